@@ src/mesh_signed_volume_accumulator_assert.svh @@
// Assertion macros shared by the mesh signed volume accumulator modules.
`ifndef MESH_SIGNED_VOLUME_ACCUMULATOR_ASSERT_SVH
`define MESH_SIGNED_VOLUME_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define MSVA_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: implication check failed");
`define MSVA_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: next-cycle check failed");
`else
`define MSVA_ASSERT_IMP(name, clk, rst, pre, post)
`define MSVA_ASSERT_NXT(name, clk, rst, pre, post)
`endif
`endif

@@ src/msva_pkg.sv @@
// Shared widths, register indexes and types of the mesh signed volume accumulator.
package msva_pkg;

   localparam int COORD_BITS      = 16;
   localparam int SUM_BITS        = 63;
   localparam int TRI_OUT_BITS    = 50;
   localparam int TOT_OUT_BITS    = 61;
   localparam int CSR_INDEX_BITS  = 2;

   localparam int DIFF_BITS       = COORD_BITS + 1;
   localparam int CROSS_BITS      = 2 * DIFF_BITS + 1;
   localparam int TERM_BITS       = DIFF_BITS + CROSS_BITS;
   localparam int PROD_BITS       = TERM_BITS + 2;
   localparam int ACC_BITS        = ((SUM_BITS > PROD_BITS) ? SUM_BITS : PROD_BITS) + 1;
   localparam int MAG_BITS        = ACC_BITS - 1;

   localparam int DIV_RADIX_STEPS = 8;
   localparam int DIV_BITS        =
      ((MAG_BITS - 1 + DIV_RADIX_STEPS - 1) / DIV_RADIX_STEPS) * DIV_RADIX_STEPS;
   localparam int DIV_CYCLES      = DIV_BITS / DIV_RADIX_STEPS;
   localparam int DIV_CNT_BITS    = $clog2(DIV_CYCLES);

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_X = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_Y = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REF_Z = CSR_INDEX_BITS'(2);

   localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS - 1){1'b1}}};
   localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS - 1){1'b0}}};

   typedef logic signed [COORD_BITS-1:0] msva_coord_type;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] a_x;
      logic signed [DIFF_BITS-1:0] a_y;
      logic signed [DIFF_BITS-1:0] a_z;
      logic signed [DIFF_BITS-1:0] b_x;
      logic signed [DIFF_BITS-1:0] b_y;
      logic signed [DIFF_BITS-1:0] b_z;
      logic signed [DIFF_BITS-1:0] c_x;
      logic signed [DIFF_BITS-1:0] c_y;
      logic signed [DIFF_BITS-1:0] c_z;
      logic                        last_triangle;
   } msva_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } msva_queue_status_type;

endpackage

@@ src/mesh_signed_volume_accumulator.sv @@
// Top level of the mesh signed volume accumulator: front end, queue and back end.
//
//   channel  ports    handshake         word
//   -------  -------  ----------------  ------------------------------------------
//   input    req_*    valid / stall     nine vertex coordinates, last_triangle
//   result   rsp_*    valid / stall     triangle and running volume, flags
//   config   csr_*    valid / ready     register index, reference coordinate
//
// From the queue to the result register a triangle passes the cross product, dot
// product, sum and saturating accumulate states, the two divide-by-six lanes
// (eight quotient bits a cycle) and the load of the result register.
// The front end takes new words into a two-entry queue while the back end works.
// Reset clears the reference point, the running total and the saturation flag.
// A stalled result holds the back end; a full queue stalls the input channel.
module mesh_signed_volume_accumulator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  msva_pkg::msva_coord_type               req_a_x,
   input  msva_pkg::msva_coord_type               req_a_y,
   input  msva_pkg::msva_coord_type               req_a_z,
   input  msva_pkg::msva_coord_type               req_b_x,
   input  msva_pkg::msva_coord_type               req_b_y,
   input  msva_pkg::msva_coord_type               req_b_z,
   input  msva_pkg::msva_coord_type               req_c_x,
   input  msva_pkg::msva_coord_type               req_c_y,
   input  msva_pkg::msva_coord_type               req_c_z,
   input  logic                                   req_last_triangle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [msva_pkg::TRI_OUT_BITS-1:0] rsp_triangle_volume,
   output logic signed [msva_pkg::TOT_OUT_BITS-1:0] rsp_running_volume,
   output logic                                   rsp_saturated,
   output logic                                   rsp_mesh_done,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [msva_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  msva_pkg::msva_coord_type               csr_data
);
   import msva_pkg::*;

   msva_queue_status_type queue_status;
   msva_item_type         push_item;
   msva_item_type         head_item;
   logic                  queue_push;
   logic                  queue_pop;

   msva_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_a_x           (req_a_x),
      .req_a_y           (req_a_y),
      .req_a_z           (req_a_z),
      .req_b_x           (req_b_x),
      .req_b_y           (req_b_y),
      .req_b_z           (req_b_z),
      .req_c_x           (req_c_x),
      .req_c_y           (req_c_y),
      .req_c_z           (req_c_z),
      .req_last_triangle (req_last_triangle),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .queue_status      (queue_status),
      .queue_push        (queue_push),
      .queue_item        (push_item)
   );

   msva_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .item_push (push_item),
      .pop       (queue_pop),
      .item_head (head_item),
      .status    (queue_status)
   );

   msva_back u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_status        (queue_status),
      .queue_item          (head_item),
      .queue_pop           (queue_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_triangle_volume (rsp_triangle_volume),
      .rsp_running_volume  (rsp_running_volume),
      .rsp_saturated       (rsp_saturated),
      .rsp_mesh_done       (rsp_mesh_done)
   );

endmodule

@@ src/msva_front.sv @@
// Front end: reference registers, word intake and vertex offset against the reference.
module msva_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  msva_pkg::msva_coord_type      req_a_x,
   input  msva_pkg::msva_coord_type      req_a_y,
   input  msva_pkg::msva_coord_type      req_a_z,
   input  msva_pkg::msva_coord_type      req_b_x,
   input  msva_pkg::msva_coord_type      req_b_y,
   input  msva_pkg::msva_coord_type      req_b_z,
   input  msva_pkg::msva_coord_type      req_c_x,
   input  msva_pkg::msva_coord_type      req_c_y,
   input  msva_pkg::msva_coord_type      req_c_z,
   input  logic                          req_last_triangle,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [msva_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  msva_pkg::msva_coord_type      csr_data,
   input  msva_pkg::msva_queue_status_type queue_status,
   output logic                          queue_push,
   output msva_pkg::msva_item_type       queue_item
);
   import msva_pkg::*;

   msva_coord_type ref_x_ff, ref_x_in;
   msva_coord_type ref_y_ff, ref_y_in;
   msva_coord_type ref_z_ff, ref_z_in;

   assign csr_ready = 1'b1;

   always_comb begin
      ref_x_in = ref_x_ff;
      ref_y_in = ref_y_ff;
      ref_z_in = ref_z_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REF_X: ref_x_in = csr_data;
            CSR_REF_Y: ref_y_in = csr_data;
            CSR_REF_Z: ref_z_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         ref_z_ff <= '0;
      end else begin
         ref_x_ff <= ref_x_in;
         ref_y_ff <= ref_y_in;
         ref_z_ff <= ref_z_in;
      end
   end

   assign req_stall  = queue_status.full;
   assign queue_push = req_valid && !queue_status.full;

   always_comb begin
      queue_item.a_x           = DIFF_BITS'(req_a_x) - DIFF_BITS'(ref_x_ff);
      queue_item.a_y           = DIFF_BITS'(req_a_y) - DIFF_BITS'(ref_y_ff);
      queue_item.a_z           = DIFF_BITS'(req_a_z) - DIFF_BITS'(ref_z_ff);
      queue_item.b_x           = DIFF_BITS'(req_b_x) - DIFF_BITS'(ref_x_ff);
      queue_item.b_y           = DIFF_BITS'(req_b_y) - DIFF_BITS'(ref_y_ff);
      queue_item.b_z           = DIFF_BITS'(req_b_z) - DIFF_BITS'(ref_z_ff);
      queue_item.c_x           = DIFF_BITS'(req_c_x) - DIFF_BITS'(ref_x_ff);
      queue_item.c_y           = DIFF_BITS'(req_c_y) - DIFF_BITS'(ref_y_ff);
      queue_item.c_z           = DIFF_BITS'(req_c_z) - DIFF_BITS'(ref_z_ff);
      queue_item.last_triangle = req_last_triangle;
   end

endmodule

@@ src/msva_queue.sv @@
// Short queue of offset triangles between the front end and the back end.
`include "mesh_signed_volume_accumulator_assert.svh"
module msva_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  msva_pkg::msva_item_type         item_push,
   input  logic                            pop,
   output msva_pkg::msva_item_type         item_head,
   output msva_pkg::msva_queue_status_type status
);
   import msva_pkg::*;

   msva_item_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign item_head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_push;
      end
   end

   `MSVA_ASSERT_IMP(a_queue_no_push_full, clock, reset, push, !status.full)
   `MSVA_ASSERT_IMP(a_queue_no_pop_empty, clock, reset, pop, !status.empty)

endmodule

@@ src/msva_div6.sv @@
// Divide-by-six lane: halve, then divide by three eight quotient bits a cycle.
`include "mesh_signed_volume_accumulator_assert.svh"
module msva_div6 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [msva_pkg::MAG_BITS-1:0] dividend,
   output logic                          busy,
   output logic [msva_pkg::DIV_BITS-1:0] quotient
);
   import msva_pkg::*;

   logic [DIV_BITS-1:0]     work_ff, work_in;
   logic [1:0]              rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;

   logic [DIV_BITS-1:0]     step_work;
   logic [1:0]              step_rem;
   logic [2:0]              step_val;
   logic                    step_bit;

   always_comb begin
      step_work = work_ff;
      step_rem  = rem_ff;
      step_val  = '0;
      step_bit  = 1'b0;
      for (int i = 0; i < DIV_RADIX_STEPS; i++) begin
         step_val  = {step_rem, step_work[DIV_BITS-1]};
         step_bit  = (step_val >= 3'd3);
         step_rem  = step_bit ? 2'(step_val - 3'd3) : step_val[1:0];
         step_work = {step_work[DIV_BITS-2:0], step_bit};
      end
   end

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         work_in = DIV_BITS'(dividend >> 1);
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = step_work;
         rem_in  = step_rem;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = work_ff;

   `MSVA_ASSERT_IMP(a_div_start_idle, clock, reset, start, !busy_ff)

endmodule

@@ src/msva_back.sv @@
// Back end: triple product, saturating accumulate, divide by six and result register.
`include "mesh_signed_volume_accumulator_assert.svh"
module msva_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  msva_pkg::msva_queue_status_type        queue_status,
   input  msva_pkg::msva_item_type                queue_item,
   output logic                                   queue_pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [msva_pkg::TRI_OUT_BITS-1:0] rsp_triangle_volume,
   output logic signed [msva_pkg::TOT_OUT_BITS-1:0] rsp_running_volume,
   output logic                                   rsp_saturated,
   output logic                                   rsp_mesh_done
);
   import msva_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CROSS = 8'b0000_0010,
      ST_DOT   = 8'b0000_0100,
      ST_SUM   = 8'b0000_1000,
      ST_ACC   = 8'b0001_0000,
      ST_MAG   = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } msva_state_type;

   msva_state_type state_ff, state_in;

   msva_item_type                item_ff, item_in;
   logic signed [CROSS_BITS-1:0] cross_x_ff, cross_x_in;
   logic signed [CROSS_BITS-1:0] cross_y_ff, cross_y_in;
   logic signed [CROSS_BITS-1:0] cross_z_ff, cross_z_in;
   logic signed [TERM_BITS-1:0]  term_x_ff, term_x_in;
   logic signed [TERM_BITS-1:0]  term_y_ff, term_y_in;
   logic signed [TERM_BITS-1:0]  term_z_ff, term_z_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic                         ovf_ff, ovf_in;
   logic signed [SUM_BITS-1:0]   res_sum_ff, res_sum_in;
   logic                         res_sat_ff, res_sat_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [TRI_OUT_BITS-1:0] rsp_tri_ff, rsp_tri_in;
   logic signed [TOT_OUT_BITS-1:0] rsp_tot_ff, rsp_tot_in;
   logic                           rsp_sat_ff, rsp_sat_in;
   logic                           rsp_done_ff, rsp_done_in;

   logic signed [2*DIFF_BITS-1:0] p_bycz, p_bzcy, p_bzcx, p_bxcz, p_bxcy, p_bycx;
   logic signed [ACC_BITS-1:0]    acc_wide;
   logic [ACC_BITS-SUM_BITS:0]    acc_top;
   logic                          acc_ovf;
   logic [SUM_BITS-1:0]           acc_val;
   logic                          mesh_close;
   logic [PROD_BITS-1:0]          prod_abs;
   logic [SUM_BITS-1:0]           sum_abs;
   logic                          div_start;
   logic                          tri_busy, tot_busy;
   logic [DIV_BITS-1:0]           tri_q, tot_q;
   logic signed [DIV_BITS:0]      tri_signed, tot_signed;
   logic                          rsp_load;

   assign p_bycz = (2*DIFF_BITS)'(item_ff.b_y) * (2*DIFF_BITS)'(item_ff.c_z);
   assign p_bzcy = (2*DIFF_BITS)'(item_ff.b_z) * (2*DIFF_BITS)'(item_ff.c_y);
   assign p_bzcx = (2*DIFF_BITS)'(item_ff.b_z) * (2*DIFF_BITS)'(item_ff.c_x);
   assign p_bxcz = (2*DIFF_BITS)'(item_ff.b_x) * (2*DIFF_BITS)'(item_ff.c_z);
   assign p_bxcy = (2*DIFF_BITS)'(item_ff.b_x) * (2*DIFF_BITS)'(item_ff.c_y);
   assign p_bycx = (2*DIFF_BITS)'(item_ff.b_y) * (2*DIFF_BITS)'(item_ff.c_x);

   assign acc_wide = ACC_BITS'(sum_ff) + ACC_BITS'(prod_ff);
   assign acc_top  = acc_wide[ACC_BITS-1:SUM_BITS-1];
   assign acc_ovf  = !((&acc_top) || !(|acc_top));
   assign acc_val  = acc_ovf ? (acc_wide[ACC_BITS-1] ? SUM_MIN : SUM_MAX)
                             : acc_wide[SUM_BITS-1:0];
   assign mesh_close = (state_ff == ST_ACC) && item_ff.last_triangle;

   assign prod_abs  = prod_ff[PROD_BITS-1] ? -prod_ff : prod_ff;
   assign sum_abs   = res_sum_ff[SUM_BITS-1] ? -res_sum_ff : res_sum_ff;
   assign div_start = (state_ff == ST_MAG);

   msva_div6 u_div_tri (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (MAG_BITS'(prod_abs)),
      .busy     (tri_busy),
      .quotient (tri_q)
   );

   msva_div6 u_div_tot (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (MAG_BITS'(sum_abs)),
      .busy     (tot_busy),
      .quotient (tot_q)
   );

   assign tri_signed = prod_ff[PROD_BITS-1] ? -$signed({1'b0, tri_q}) : $signed({1'b0, tri_q});
   assign tot_signed = res_sum_ff[SUM_BITS-1] ? -$signed({1'b0, tot_q}) : $signed({1'b0, tot_q});

   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign queue_pop = (state_ff == ST_IDLE) && !queue_status.empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!queue_status.empty) state_in = ST_CROSS;
         ST_CROSS: state_in = ST_DOT;
         ST_DOT:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_MAG;
         ST_MAG:   state_in = ST_DIV;
         ST_DIV:   if (!tri_busy) state_in = ST_OUT;
         ST_OUT:   if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_in    = queue_pop ? queue_item : item_ff;
      cross_x_in = cross_x_ff;
      cross_y_in = cross_y_ff;
      cross_z_in = cross_z_ff;
      term_x_in  = term_x_ff;
      term_y_in  = term_y_ff;
      term_z_in  = term_z_ff;
      prod_in    = prod_ff;
      sum_in     = sum_ff;
      ovf_in     = ovf_ff;
      res_sum_in = res_sum_ff;
      res_sat_in = res_sat_ff;
      if (state_ff == ST_CROSS) begin
         cross_x_in = CROSS_BITS'(p_bycz) - CROSS_BITS'(p_bzcy);
         cross_y_in = CROSS_BITS'(p_bzcx) - CROSS_BITS'(p_bxcz);
         cross_z_in = CROSS_BITS'(p_bxcy) - CROSS_BITS'(p_bycx);
      end
      if (state_ff == ST_DOT) begin
         term_x_in = TERM_BITS'(item_ff.a_x) * TERM_BITS'(cross_x_ff);
         term_y_in = TERM_BITS'(item_ff.a_y) * TERM_BITS'(cross_y_ff);
         term_z_in = TERM_BITS'(item_ff.a_z) * TERM_BITS'(cross_z_ff);
      end
      if (state_ff == ST_SUM) begin
         prod_in = PROD_BITS'(term_x_ff) + PROD_BITS'(term_y_ff) + PROD_BITS'(term_z_ff);
      end
      if (state_ff == ST_ACC) begin
         res_sum_in = acc_val;
         res_sat_in = ovf_ff || acc_ovf;
         sum_in     = mesh_close ? '0 : acc_val;
         ovf_in     = mesh_close ? 1'b0 : (ovf_ff || acc_ovf);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_tri_in   = rsp_tri_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_tri_in   = TRI_OUT_BITS'(tri_signed);
         rsp_tot_in   = TOT_OUT_BITS'(tot_signed);
         rsp_sat_in   = res_sat_ff;
         rsp_done_in  = item_ff.last_triangle;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      cross_x_ff  <= cross_x_in;
      cross_y_ff  <= cross_y_in;
      cross_z_ff  <= cross_z_in;
      term_x_ff   <= term_x_in;
      term_y_ff   <= term_y_in;
      term_z_ff   <= term_z_in;
      prod_ff     <= prod_in;
      res_sum_ff  <= res_sum_in;
      res_sat_ff  <= res_sat_in;
      rsp_tri_ff  <= rsp_tri_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_triangle_volume = rsp_tri_ff;
   assign rsp_running_volume  = rsp_tot_ff;
   assign rsp_saturated       = rsp_sat_ff;
   assign rsp_mesh_done       = rsp_done_ff;

   `MSVA_ASSERT_IMP(a_back_lanes_agree, clock, reset, 1'b1, tri_busy == tot_busy)
   `MSVA_ASSERT_NXT(a_back_mesh_clear, clock, reset, mesh_close, (sum_ff == '0) && !ovf_ff)
   `MSVA_ASSERT_IMP(a_back_out_after_div, clock, reset, rsp_load, !tri_busy && !tot_busy)

endmodule
